// ===== rtl/averaged_swr_power_meter_defines.svh =====
// Assertion macros shared by the SWR power meter RTL.
`ifndef AVERAGED_SWR_POWER_METER_DEFINES_SVH
`define AVERAGED_SWR_POWER_METER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, ignored during reset.
`define ASWR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aswr assertion failed");
// Next-cycle implication, sampled on clk, ignored during reset.
`define ASWR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aswr assertion failed");
`else
`define ASWR_ASSERT_IMP(name, ante, cons)
`define ASWR_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== rtl/aswr_pkg.sv =====
// Shared widths, defaults and register indexes of the SWR power meter.
package aswr_pkg;

    localparam int unsigned SampleW       = 12;
    localparam int unsigned SumW          = 20;
    localparam int unsigned CoefW         = 48;
    localparam int unsigned PowW          = 32;
    localparam int unsigned SwrW          = 24;
    localparam int unsigned AccW          = 72;
    localparam int unsigned CfgIdxW       = 2;
    localparam int unsigned WinLenDefault = 16;

    localparam logic [PowW-1:0] MinFwdReset = 32'd13107;

    localparam logic [CfgIdxW-1:0] CfgCoefSquare = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgCoefLinear = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCoefOffset = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgMinForward = 2'd3;

endpackage

// ===== rtl/aswr_window.sv =====
// Sliding windows of forward and reflected samples with running sums and means.
module aswr_window
    import aswr_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH = WinLenDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SampleW-1:0] fwd_in,
    input  logic [SampleW-1:0] rev_in,
    output logic               done,
    output logic [SampleW-1:0] fwd_mean,
    output logic [SampleW-1:0] rev_mean
);

    localparam int unsigned PosW     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int unsigned DivShift = SumW + $clog2(WINDOW_LENGTH);
    localparam int unsigned RecipW   = SumW + 2;
    localparam int unsigned ProdW    = SumW + RecipW;
    localparam longint unsigned RecipVal =
        ((64'd1 << DivShift) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam logic [RecipW-1:0] Recip   = RecipW'(RecipVal);
    localparam logic [PosW-1:0]   LastPos = PosW'(WINDOW_LENGTH - 1);

    logic [SampleW-1:0] fwd_mem [WINDOW_LENGTH];
    logic [SampleW-1:0] rev_mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] entry_vld_reg;
    logic [PosW-1:0]    pos_reg;
    logic               rd_phase_reg;
    logic               sum_phase_reg;
    logic               done_reg;
    logic               old_vld_reg;
    logic [SampleW-1:0] fwd_new_reg;
    logic [SampleW-1:0] rev_new_reg;
    logic [SampleW-1:0] fwd_old_reg;
    logic [SampleW-1:0] rev_old_reg;
    logic [SumW-1:0]    fwd_sum_reg;
    logic [SumW-1:0]    rev_sum_reg;
    logic [SumW-1:0]    fwd_sum_next;
    logic [SumW-1:0]    rev_sum_next;
    logic [SampleW-1:0] fwd_mean_reg;
    logic [SampleW-1:0] rev_mean_reg;
    logic [ProdW-1:0]   fwd_prod;
    logic [ProdW-1:0]   rev_prod;

    // Entries never written read as zero
    assign fwd_sum_next = fwd_sum_reg - (old_vld_reg ? SumW'(fwd_old_reg) : '0)
                        + SumW'(fwd_new_reg);
    assign rev_sum_next = rev_sum_reg - (old_vld_reg ? SumW'(rev_old_reg) : '0)
                        + SumW'(rev_new_reg);

    // Floor divide by the window length through a reciprocal multiply
    assign fwd_prod = ProdW'(fwd_sum_reg) * ProdW'(Recip);
    assign rev_prod = ProdW'(rev_sum_reg) * ProdW'(Recip);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            fwd_new_reg <= fwd_in;
            rev_new_reg <= rev_in;
            fwd_old_reg <= fwd_mem[pos_reg];
            rev_old_reg <= rev_mem[pos_reg];
        end
        if (rd_phase_reg)
        begin
            fwd_mem[pos_reg] <= fwd_new_reg;
            rev_mem[pos_reg] <= rev_new_reg;
        end
        if (sum_phase_reg)
        begin
            fwd_mean_reg <= fwd_prod[DivShift +: SampleW];
            rev_mean_reg <= rev_prod[DivShift +: SampleW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
            pos_reg       <= '0;
            rd_phase_reg  <= 1'b0;
            sum_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
            old_vld_reg   <= 1'b0;
            fwd_sum_reg   <= '0;
            rev_sum_reg   <= '0;
        end
        else
        begin
            rd_phase_reg  <= start;
            sum_phase_reg <= rd_phase_reg;
            done_reg      <= sum_phase_reg;
            if (start)
            begin
                old_vld_reg <= entry_vld_reg[pos_reg];
            end
            if (rd_phase_reg)
            begin
                entry_vld_reg[pos_reg] <= 1'b1;
                fwd_sum_reg <= fwd_sum_next;
                rev_sum_reg <= rev_sum_next;
                pos_reg     <= (pos_reg == LastPos) ? '0 : pos_reg + PosW'(1);
            end
        end
    end

    assign done     = done_reg;
    assign fwd_mean = fwd_mean_reg;
    assign rev_mean = rev_mean_reg;

endmodule

// ===== rtl/averaged_swr_power_meter.sv =====
// Top level of the averaged SWR power meter: sequencer and shared arithmetic unit.
`include "averaged_swr_power_meter_defines.svh"

// Each accepted word carries one forward and one reflected detector sample.
// The samples enter two sliding windows of WINDOW_LENGTH scans; the window
// means go through the quadratic calibration coef_square*m*m + coef_linear*m
// + coef_offset (Q16.32), clamped at zero and saturated into Q16.16 powers.
// SWR = (F + R + 2*isqrt(F*R)) / (F - R) is produced in Q8.16. All products,
// the square root and the quotient run on one 72-bit add/subtract unit under
// a one-hot sequencer: shift-add multiplies one bit a cycle, a restoring
// square root two bits a cycle, a restoring divide one quotient bit a cycle.
// A word passes through the window, both calibrations, the F*R product, the
// root, the divide and the output load when the SWR is computed, and skips
// the product, root and divide when forward power is zero or is below
// min_forward_power, or reflected power reaches forward power. in_ready
// is high only while the sequencer is idle; a result sits in the output
// register until taken while the next word is accepted. Configuration
// writes take effect at once and are meant for idle periods.
module averaged_swr_power_meter
    import aswr_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH = WinLenDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SampleW-1:0] forward_sample,
    input  logic [SampleW-1:0] reflected_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PowW-1:0]    forward_power,
    output logic [SwrW-1:0]    swr_value,
    output logic               swr_valid,
    output logic               swr_saturated,
    input  logic               cfg_write,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CoefW-1:0]   cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_WAIT    = 12'b0000_0000_0010,
        S_MUL_SQ  = 12'b0000_0000_0100,
        S_MUL_T   = 12'b0000_0000_1000,
        S_MUL_LIN = 12'b0000_0001_0000,
        S_ADD_OFS = 12'b0000_0010_0000,
        S_POWER   = 12'b0000_0100_0000,
        S_MUL_FR  = 12'b0000_1000_0000,
        S_SQRT    = 12'b0001_0000_0000,
        S_DSET    = 12'b0010_0000_0000,
        S_DIV     = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } state_t;

    localparam logic [SwrW-1:0] SwrMax = '1;
    localparam logic [PowW-1:0] PowMax = '1;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic [CoefW-1:0] coef_square_reg;
    logic [CoefW-1:0] coef_linear_reg;
    logic [CoefW-1:0] coef_offset_reg;
    logic [PowW-1:0]  min_fwd_reg;

    // sequencer and datapath registers
    logic [4:0]       cnt_reg;
    logic             side_reg;
    logic [AccW-1:0]  acc_reg;
    logic [AccW-1:0]  mcand_reg;
    logic [31:0]      mplier_reg;
    logic             ovf_hi_reg;
    logic             ovf_lo_reg;
    logic [PowW-1:0]  fwd_pow_reg;
    logic [PowW-1:0]  rev_pow_reg;

    // output register
    logic             out_valid_reg;
    logic [PowW-1:0]  forward_power_reg;
    logic [SwrW-1:0]  swr_reg;
    logic             swr_valid_reg;
    logic             swr_sat_reg;

    // window interface
    logic               win_start;
    logic               mean_done;
    logic [SampleW-1:0] fwd_mean;
    logic [SampleW-1:0] rev_mean;
    logic [SampleW-1:0] mean_sel;

    // shared arithmetic unit
    logic [AccW-1:0]  alu_a;
    logic [AccW-1:0]  alu_b;
    logic             alu_sub;
    logic [AccW-1:0]  alu_sum;
    logic             alu_neg;

    logic [63:0]      sq_bit;
    logic [63:0]      sq_trial;
    logic [PowW-1:0]  pow_val;
    logic             prod_hi;
    logic             prod_lo;
    logic [34:0]      swr_num;
    logic [PowW-1:0]  swr_den;
    logic             cnt_zero;
    logic             load_out;
    logic             res_valid;
    logic             res_sat;
    logic [SwrW-1:0]  res_swr;

    aswr_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (win_start),
        .fwd_in   (forward_sample),
        .rev_in   (reflected_sample),
        .done     (mean_done),
        .fwd_mean (fwd_mean),
        .rev_mean (rev_mean)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign win_start = in_valid && in_ready;
    assign mean_sel  = side_reg ? rev_mean : fwd_mean;
    assign cnt_zero  = (cnt_reg == 5'd0);

    // Root trial bit is 4^cnt; it never overlaps the partial root held in mcand
    assign sq_bit   = 64'd1 << {cnt_reg, 1'b0};
    assign sq_trial = mcand_reg[63:0] | sq_bit;

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_MUL_SQ, S_MUL_T, S_MUL_LIN, S_MUL_FR:
            begin
                alu_b = mplier_reg[0] ? mcand_reg : '0;
            end
            S_ADD_OFS:
            begin
                alu_b = {{(AccW-CoefW){coef_offset_reg[CoefW-1]}}, coef_offset_reg};
            end
            S_SQRT:
            begin
                alu_b   = AccW'(sq_trial);
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_b   = mcand_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_b = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AccW'(alu_sub);
    assign alu_neg = alu_sum[AccW-1];

    // Square term overflow: product magnitude at least 2^61
    assign prod_hi = !alu_sum[AccW-1] && (|alu_sum[AccW-2:61]);
    assign prod_lo = alu_sum[AccW-1] && (!(&alu_sum[AccW-2:61]) || (alu_sum[60:0] == '0));

    // Clamp at zero, drop the low 16 fraction bits, saturate at full scale
    always_comb
    begin
        if (ovf_hi_reg)
        begin
            pow_val = PowMax;
        end
        else if (ovf_lo_reg || acc_reg[AccW-1])
        begin
            pow_val = '0;
        end
        else if (|acc_reg[AccW-1:CoefW])
        begin
            pow_val = PowMax;
        end
        else
        begin
            pow_val = acc_reg[CoefW-1:16];
        end
    end

    assign swr_num = 35'(fwd_pow_reg) + 35'(rev_pow_reg) + {2'b00, mcand_reg[31:0], 1'b0};
    assign swr_den = fwd_pow_reg - rev_pow_reg;

    // Result flags: invalid when zero or below threshold, saturated when reflected reaches forward or
    // the quotient reaches 2^24
    always_comb
    begin
        res_valid = (fwd_pow_reg != '0) && (fwd_pow_reg >= min_fwd_reg);
        res_sat   = 1'b0;
        res_swr   = '0;
        if (res_valid)
        begin
            if (rev_pow_reg >= fwd_pow_reg)
            begin
                res_sat = 1'b1;
                res_swr = SwrMax;
            end
            else if (mplier_reg[SwrW])
            begin
                res_sat = 1'b1;
                res_swr = SwrMax;
            end
            else
            begin
                res_swr = mplier_reg[SwrW-1:0];
            end
        end
    end

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_WAIT;
            S_WAIT:    if (mean_done) state_next = S_MUL_SQ;
            S_MUL_SQ:  if (cnt_zero) state_next = S_MUL_T;
            S_MUL_T:   if (cnt_zero) state_next = S_MUL_LIN;
            S_MUL_LIN: if (cnt_zero) state_next = S_ADD_OFS;
            S_ADD_OFS: state_next = S_POWER;
            S_POWER:
            begin
                if (!side_reg)
                begin
                    state_next = S_MUL_SQ;
                end
                else if ((fwd_pow_reg != '0) && (fwd_pow_reg >= min_fwd_reg)
                         && (pow_val < fwd_pow_reg))
                begin
                    state_next = S_MUL_FR;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MUL_FR:  if (cnt_zero) state_next = S_SQRT;
            S_SQRT:    if (cnt_zero) state_next = S_DSET;
            S_DSET:    state_next = S_DIV;
            S_DIV:     if (cnt_zero) state_next = S_OUT;
            S_OUT:     if (load_out) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            side_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            coef_square_reg <= '0;
            coef_linear_reg <= '0;
            coef_offset_reg <= '0;
            min_fwd_reg     <= MinFwdReset;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CfgCoefSquare: coef_square_reg <= cfg_data;
                    CfgCoefLinear: coef_linear_reg <= cfg_data;
                    CfgCoefOffset: coef_offset_reg <= cfg_data;
                    CfgMinForward: min_fwd_reg     <= cfg_data[PowW-1:0];
                endcase
            end

            // Reload the step counter on every phase change, else count down
            if (state_next != state_reg || state_reg == S_POWER)
            begin
                unique case (state_next)
                    S_MUL_FR, S_SQRT: cnt_reg <= 5'd31;
                    S_DIV:            cnt_reg <= 5'(SwrW);
                    default:          cnt_reg <= 5'(SampleW - 1);
                endcase
            end
            else if (!cnt_zero)
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end

            if (state_reg == S_WAIT)
            begin
                side_reg <= 1'b0;
            end
            else if (state_reg == S_POWER)
            begin
                side_reg <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_WAIT:
            begin
                acc_reg    <= '0;
                mcand_reg  <= {{(AccW-CoefW){coef_square_reg[CoefW-1]}}, coef_square_reg};
                mplier_reg <= 32'(fwd_mean);
            end
            S_MUL_SQ, S_MUL_T, S_MUL_LIN, S_MUL_FR:
            begin
                acc_reg    <= alu_sum;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                if (cnt_zero)
                begin
                    unique case (state_reg)
                        S_MUL_SQ:
                        begin
                            // Square the mean: feed a2*m back as the multiplicand
                            acc_reg    <= '0;
                            mcand_reg  <= alu_sum;
                            mplier_reg <= 32'(mean_sel);
                        end
                        S_MUL_T:
                        begin
                            ovf_hi_reg <= prod_hi;
                            ovf_lo_reg <= prod_lo;
                            mcand_reg  <= {{(AccW-CoefW){coef_linear_reg[CoefW-1]}},
                                           coef_linear_reg};
                            mplier_reg <= 32'(mean_sel);
                        end
                        S_MUL_FR:
                        begin
                            // Start the root with an empty partial result
                            mcand_reg <= '0;
                        end
                        default:
                        begin
                            mcand_reg <= mcand_reg << 1;
                        end
                    endcase
                end
            end
            S_ADD_OFS:
            begin
                acc_reg <= alu_sum;
            end
            S_POWER:
            begin
                acc_reg <= '0;
                if (!side_reg)
                begin
                    fwd_pow_reg <= pow_val;
                    mcand_reg   <= {{(AccW-CoefW){coef_square_reg[CoefW-1]}},
                                    coef_square_reg};
                    mplier_reg  <= 32'(rev_mean);
                end
                else
                begin
                    rev_pow_reg <= pow_val;
                    mcand_reg   <= AccW'(fwd_pow_reg);
                    mplier_reg  <= pow_val;
                end
            end
            S_SQRT:
            begin
                if (!alu_neg)
                begin
                    acc_reg   <= alu_sum;
                    mcand_reg <= AccW'((mcand_reg[63:0] >> 1) | sq_bit);
                end
                else
                begin
                    mcand_reg <= AccW'(mcand_reg[63:0] >> 1);
                end
            end
            S_DSET:
            begin
                acc_reg    <= AccW'({swr_num, 16'b0});
                mcand_reg  <= AccW'(swr_den) << SwrW;
                mplier_reg <= '0;
            end
            S_DIV:
            begin
                if (!alu_neg)
                begin
                    acc_reg <= alu_sum;
                end
                mplier_reg <= {mplier_reg[30:0], !alu_neg};
                mcand_reg  <= mcand_reg >> 1;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase

        if (load_out)
        begin
            forward_power_reg <= fwd_pow_reg;
            swr_reg           <= res_swr;
            swr_valid_reg     <= res_valid;
            swr_sat_reg       <= res_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign forward_power = forward_power_reg;
    assign swr_value     = swr_reg;
    assign swr_valid     = swr_valid_reg;
    assign swr_saturated = swr_sat_reg;

    `ASWR_ASSERT_IMP(a_sat_needs_valid, out_valid && swr_saturated, swr_valid)
    `ASWR_ASSERT_IMP(a_sat_is_max, out_valid && swr_saturated, swr_value == SwrMax)
    `ASWR_ASSERT_IMP(a_mean_only_waiting, mean_done, state_reg == S_WAIT)
    `ASWR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule
